// ===== sv/spi_serial_sram_slave_top_assert.svh =====
// ---------------------------------------------------------------------------
// SPI serial SRAM slave assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef SPI_SERIAL_SRAM_SLAVE_TOP_ASSERT_SVH
`define SPI_SERIAL_SRAM_SLAVE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// check outside reset
`define SSRAM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check at every edge, reset included
`define SSRAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSRAM_ASSERT(lbl, clk, rstn, prop, msg)
`define SSRAM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/ssram_pkg.sv =====
// ---------------------------------------------------------------------------
// SPI serial SRAM slave package
// Instruction codes, phase and command types, shared structs.
// ---------------------------------------------------------------------------
package ssram_pkg;

    localparam int MEM_BYTES_DEF = 32768;
    localparam int ADDR_BITS_DEF = 15;

    localparam logic [7:0] INSTR_RDSR  = 8'h05;
    localparam logic [7:0] INSTR_WRSR  = 8'h01;
    localparam logic [7:0] INSTR_READ  = 8'h03;
    localparam logic [7:0] INSTR_WRITE = 8'h02;
    localparam logic [7:0] MODE_MASK   = 8'hC0;
    localparam logic [7:0] MODE_SEQ    = 8'h40;

    typedef enum logic [2:0] {
        PH_INSTR   = 3'd0,
        PH_ADDR_HI = 3'd1,
        PH_ADDR_LO = 3'd2,
        PH_DATA    = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_RDSR    = 3'd1,
        CMD_WRSR    = 3'd2,
        CMD_READ    = 3'd3,
        CMD_WRITE   = 3'd4,
        CMD_UNKNOWN = 3'd5
    } cmd_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_req_t;

endpackage

// ===== sv/ssram_mem.sv =====
// ---------------------------------------------------------------------------
// SPI serial SRAM storage array
// Single-port byte array with registered read data.
// ---------------------------------------------------------------------------
module ssram_mem #(
    parameter int MEM_BYTES = ssram_pkg::MEM_BYTES_DEF,
    parameter int ADDR_BITS = ssram_pkg::ADDR_BITS_DEF
) (
    input  logic                   aclk,
    input  ssram_pkg::mem_req_t    req,
    input  logic [((ADDR_BITS < $clog2(MEM_BYTES)) ? ADDR_BITS : $clog2(MEM_BYTES))-1:0] addr,
    input  logic [7:0]             wr_data,
    output logic [7:0]             rd_data
);

    localparam int IDX_W = $clog2(MEM_BYTES);

    logic [7:0]       mem_array [MEM_BYTES];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] idx;

    assign idx     = IDX_W'(addr);
    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_array[idx] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem_array[idx];
        end
    end

endmodule

// ===== sv/ssram_ctrl.sv =====
// ---------------------------------------------------------------------------
// SPI serial SRAM command sequencer
// Decodes instruction, address and data beats; holds status and pointer.
// ---------------------------------------------------------------------------
`include "spi_serial_sram_slave_top_assert.svh"

module ssram_ctrl #(
    parameter int MEM_BYTES = ssram_pkg::MEM_BYTES_DEF,
    parameter int ADDR_BITS = ssram_pkg::ADDR_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   proc,
    input  logic                   start,
    input  logic [7:0]             mosi,
    output ssram_pkg::mem_req_t    mem_req,
    output logic [((ADDR_BITS < $clog2(MEM_BYTES)) ? ADDR_BITS : $clog2(MEM_BYTES))-1:0] ptr,
    output logic [7:0]             miso_val
);

    localparam int IDX_W = $clog2(MEM_BYTES);
    localparam int AW    = (ADDR_BITS < IDX_W) ? ADDR_BITS : IDX_W;

    ssram_pkg::phase_t phase_reg, phase_next;
    ssram_pkg::cmd_t   cmd_reg, cmd_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [7:0]        status_reg, status_next;

    logic              instr_hit;
    logic              seq_mode;
    logic [15:0]       ptr16;
    logic [15:0]       word_hi;
    logic [15:0]       word_lo;

    assign instr_hit = start || (phase_reg == ssram_pkg::PH_INSTR);
    assign seq_mode  = (status_reg & ssram_pkg::MODE_MASK) == ssram_pkg::MODE_SEQ;
    assign ptr16     = 16'(ptr_reg);
    assign word_hi   = {mosi, 8'h00};
    assign word_lo   = {ptr16[15:8], mosi};
    assign ptr       = ptr_reg;

    always_comb begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        if (proc) begin
            if (instr_hit) begin
                case (mosi)
                    ssram_pkg::INSTR_RDSR: begin
                        cmd_next   = ssram_pkg::CMD_RDSR;
                        phase_next = ssram_pkg::PH_DATA;
                    end
                    ssram_pkg::INSTR_WRSR: begin
                        cmd_next   = ssram_pkg::CMD_WRSR;
                        phase_next = ssram_pkg::PH_DATA;
                    end
                    ssram_pkg::INSTR_READ: begin
                        cmd_next   = ssram_pkg::CMD_READ;
                        phase_next = ssram_pkg::PH_ADDR_HI;
                    end
                    ssram_pkg::INSTR_WRITE: begin
                        cmd_next   = ssram_pkg::CMD_WRITE;
                        phase_next = ssram_pkg::PH_ADDR_HI;
                    end
                    default: begin
                        cmd_next   = ssram_pkg::CMD_UNKNOWN;
                        phase_next = ssram_pkg::PH_DONE;
                    end
                endcase
            end else begin
                case (phase_reg)
                    ssram_pkg::PH_ADDR_HI: begin
                        ptr_next   = word_hi[AW-1:0];
                        phase_next = ssram_pkg::PH_ADDR_LO;
                    end
                    ssram_pkg::PH_ADDR_LO: begin
                        ptr_next   = word_lo[AW-1:0];
                        phase_next = ssram_pkg::PH_DATA;
                    end
                    ssram_pkg::PH_DATA: begin
                        case (cmd_reg)
                            ssram_pkg::CMD_RDSR: begin
                                phase_next = ssram_pkg::PH_DATA;
                            end
                            ssram_pkg::CMD_WRSR: begin
                                status_next = mosi;
                                phase_next  = ssram_pkg::PH_DONE;
                            end
                            ssram_pkg::CMD_READ, ssram_pkg::CMD_WRITE: begin
                                if (seq_mode) begin
                                    ptr_next = ptr_reg + AW'(1);
                                end else begin
                                    phase_next = ssram_pkg::PH_DONE;
                                end
                            end
                            default: begin
                                phase_next = ssram_pkg::PH_DONE;
                            end
                        endcase
                    end
                    default: begin
                        phase_next = ssram_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        mem_req  = '0;
        miso_val = 8'h00;
        if (proc && !instr_hit && (phase_reg == ssram_pkg::PH_DATA)) begin
            case (cmd_reg)
                ssram_pkg::CMD_RDSR:  miso_val      = status_reg;
                ssram_pkg::CMD_READ:  mem_req.rd_en = 1'b1;
                ssram_pkg::CMD_WRITE: mem_req.wr_en = 1'b1;
                default:              miso_val      = 8'h00;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= ssram_pkg::PH_INSTR;
            cmd_reg    <= ssram_pkg::CMD_NONE;
            ptr_reg    <= '0;
            status_reg <= 8'h00;
        end else begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            ptr_reg    <= ptr_next;
            status_reg <= status_next;
        end
    end

    `SSRAM_ASSERT(a_rd_wr_excl, aclk, aresetn, !(mem_req.rd_en && mem_req.wr_en), "read and write together")
    `SSRAM_ASSERT(a_addr_cmd, aclk, aresetn, ((phase_reg == ssram_pkg::PH_ADDR_HI) || (phase_reg == ssram_pkg::PH_ADDR_LO)) |-> ((cmd_reg == ssram_pkg::CMD_READ) || (cmd_reg == ssram_pkg::CMD_WRITE)), "address phase without memory command")
    `SSRAM_ASSERT(a_busy_cmd, aclk, aresetn, (phase_reg != ssram_pkg::PH_INSTR) |-> (cmd_reg != ssram_pkg::CMD_NONE), "phase advanced without command")

endmodule

// ===== sv/spi_serial_sram_slave_top.sv =====
// ---------------------------------------------------------------------------
// SPI serial SRAM slave top level
// Byte-level model of a serial SRAM: status, read and write instructions.
//
//   channel   dir   tdata            tuser
//   s_        in    mosi_byte[7:0]   transaction_start
//   m_        out   miso_byte[7:0]   -
//
// One beat in per cycle while m_tready stays high, one beat out for each beat in.
// From s_ accept to m_tvalid a beat passes the input register, then the
// state update and registered memory read into the result register.
// Reset clears control state and status; memory contents are not cleared.
// A stall on m_ holds the result; s_tready drops only when both stages are full.
// ---------------------------------------------------------------------------
`include "spi_serial_sram_slave_top_assert.svh"

module spi_serial_sram_slave_top #(
    parameter int MEM_BYTES = ssram_pkg::MEM_BYTES_DEF,
    parameter int ADDR_BITS = ssram_pkg::ADDR_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] mosi_byte
    input  logic       s_tuser,   // [0] transaction_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] miso_byte
);

    localparam int IDX_W = $clog2(MEM_BYTES);
    localparam int AW    = (ADDR_BITS < IDX_W) ? ADDR_BITS : IDX_W;

    logic                in_valid_reg;
    logic                in_start_reg;
    logic [7:0]          in_mosi_reg;
    logic                out_valid_reg;
    logic                out_sel_reg;
    logic [7:0]          out_miso_reg;

    logic                advance;
    ssram_pkg::mem_req_t mem_req;
    logic [AW-1:0]       ptr;
    logic [7:0]          miso_val;
    logic [7:0]          rd_data;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sel_reg ? rd_data : out_miso_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_start_reg <= s_tuser;
            in_mosi_reg  <= s_tdata;
        end
        if (advance) begin
            out_sel_reg  <= mem_req.rd_en;
            out_miso_reg <= miso_val;
        end
    end

    ssram_ctrl #(
        .MEM_BYTES (MEM_BYTES),
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .proc     (advance),
        .start    (in_start_reg),
        .mosi     (in_mosi_reg),
        .mem_req  (mem_req),
        .ptr      (ptr),
        .miso_val (miso_val)
    );

    ssram_mem #(
        .MEM_BYTES (MEM_BYTES),
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .addr    (ptr),
        .wr_data (in_mosi_reg),
        .rd_data (rd_data)
    );

    `SSRAM_ASSERT(a_ready_full, aclk, aresetn, !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready), "input stalled with room")
    `SSRAM_ASSERT(a_adv_out, aclk, aresetn, advance |=> out_valid_reg, "processed beat lost")
    `SSRAM_ASSERT(a_hold_res, aclk, aresetn, (out_valid_reg && !m_tready) |=> ($stable(out_sel_reg) && $stable(out_miso_reg)), "stalled result changed")

endmodule
